// ===== design/barrier_gate_sequencer_top_defines.svh =====
// Assertion macros used by the barrier gate sequencer checker.
`ifndef BARRIER_GATE_SEQUENCER_TOP_DEFINES_SVH
`define BARRIER_GATE_SEQUENCER_TOP_DEFINES_SVH

// Implication checked in the same cycle, sampled on clk, off during reset.
`define BGS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("barrier gate sequencer check failed");

// Implication checked in the cycle after, sampled on clk, off during reset.
`define BGS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("barrier gate sequencer check failed");

`endif

// ===== design/bgs_pkg.sv =====
// Types, codes and layout constants of the barrier gate sequencer.
package bgs_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_W      = 24;
    localparam int NOW_W      = 32;
    localparam int DUR_W      = 24;
    localparam int KIND_W     = 3;
    localparam int CODE_W     = 4;
    localparam int FAULT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;

    // Bit positions of the result word.
    localparam int OUT_CODE_LSB   = 0;
    localparam int OUT_GREEN_BIT  = 4;
    localparam int OUT_OPEN_BIT   = 5;
    localparam int OUT_CLOSE_BIT  = 6;
    localparam int OUT_CYCLE_BIT  = 7;
    localparam int OUT_FAULT_LSB  = 8;
    localparam int OUT_ACCEPT_BIT = 11;

    typedef logic [TIME_W-1:0] tstamp_t;

    typedef enum logic [10:0] {
        ST_STARTUP   = 11'b000_0000_0001,
        ST_IDLE      = 11'b000_0000_0010,
        ST_RECOG     = 11'b000_0000_0100,
        ST_DENIED    = 11'b000_0000_1000,
        ST_OPENING   = 11'b000_0001_0000,
        ST_OPEN      = 11'b000_0010_0000,
        ST_PASSING   = 11'b000_0100_0000,
        ST_CLEARANCE = 11'b000_1000_0000,
        ST_CLOSING   = 11'b001_0000_0000,
        ST_REARMING  = 11'b010_0000_0000,
        ST_FAULT     = 11'b100_0000_0000
    } gate_st_t;

    localparam logic [CODE_W-1:0] CODE_STARTUP   = 4'd0;
    localparam logic [CODE_W-1:0] CODE_IDLE      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_RECOG     = 4'd2;
    localparam logic [CODE_W-1:0] CODE_DENIED    = 4'd3;
    localparam logic [CODE_W-1:0] CODE_OPENING   = 4'd4;
    localparam logic [CODE_W-1:0] CODE_OPEN      = 4'd5;
    localparam logic [CODE_W-1:0] CODE_PASSING   = 4'd6;
    localparam logic [CODE_W-1:0] CODE_CLEARANCE = 4'd7;
    localparam logic [CODE_W-1:0] CODE_CLOSING   = 4'd8;
    localparam logic [CODE_W-1:0] CODE_REARMING  = 4'd9;
    localparam logic [CODE_W-1:0] CODE_FAULT     = 4'd10;

    typedef enum logic [KIND_W-1:0] {
        KIND_UPDATE       = 3'd0,
        KIND_RECOGNITION  = 3'd1,
        KIND_ACK_FAULT    = 3'd2,
        KIND_MANUAL_OPEN  = 3'd3,
        KIND_MANUAL_CLOSE = 3'd4,
        KIND_LIGHT_TEST   = 3'd5
    } kind_t;

    typedef enum logic [FAULT_W-1:0] {
        FAULT_NONE          = 3'd0,
        FAULT_RECOG_TIMEOUT = 3'd1,
        FAULT_NO_PASSAGE    = 3'd2,
        FAULT_BLOCKED       = 3'd3,
        FAULT_RECOG_FAILED  = 3'd4
    } fault_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEBOUNCE        = 3'd0,
        REG_RELAY_PULSE     = 3'd1,
        REG_RECOG_TIMEOUT   = 3'd2,
        REG_OPENING_TRAVEL  = 3'd3,
        REG_PASSAGE_TIMEOUT = 3'd4,
        REG_CLEARANCE       = 3'd5,
        REG_CLOSING_TRAVEL  = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] debounce;
        logic [CFG_W-1:0] relay_pulse;
        logic [CFG_W-1:0] recog_timeout;
        logic [CFG_W-1:0] opening_travel;
        logic [CFG_W-1:0] passage_timeout;
        logic [CFG_W-1:0] clearance;
        logic [CFG_W-1:0] closing_travel;
    } cfg_t;

    typedef struct packed {
        kind_t            kind;
        tstamp_t          now;
        logic             loop_present;
        logic             passage_blocked;
        logic             authorized;
        logic             system_error;
        logic             override_green;
        logic [DUR_W-1:0] override_dur;
    } item_t;

    typedef struct packed {
        gate_st_t st;
        logic     started;
        tstamp_t  entered_at;
        tstamp_t  occ_since;
        logic     occ_valid;
        tstamp_t  clr_since;
        logic     clr_valid;
        tstamp_t  pulse_end;
        logic     ovr_active;
        logic     ovr_level;
        tstamp_t  ovr_end;
        fault_t   fault_reason;
    } ctx_t;

    typedef struct packed {
        logic [CODE_W-1:0] gate_code;
        logic              green;
        logic              req_open;
        logic              req_close;
        logic              cycle_active;
        fault_t            fault_code;
        logic              accepted;
    } result_t;

endpackage

// ===== design/bgs_step.sv =====
// Next-state and result logic of the barrier gate sequencer for one word.
module bgs_step (
    input  bgs_pkg::cfg_t    cfg,
    input  bgs_pkg::ctx_t    cur,
    input  bgs_pkg::item_t   item,
    output bgs_pkg::ctx_t    nxt,
    output bgs_pkg::result_t res
);
    import bgs_pkg::*;

    // True when a is at or after b on the wrapping time line.
    function automatic logic at_or_after(input tstamp_t a, input tstamp_t b);
        tstamp_t d;
        d = a - b;
        return !d[TIME_W-1];
    endfunction

    function automatic logic elapsed(input tstamp_t now, input tstamp_t since,
                                     input logic [CFG_W-1:0] limit);
        tstamp_t d;
        d = now - since;
        return !d[TIME_W-1] && (d >= TIME_W'(limit));
    endfunction

    function automatic logic [CODE_W-1:0] state_code(input gate_st_t st);
        logic [CODE_W-1:0] c;
        unique case (st)
            ST_STARTUP:   c = CODE_STARTUP;
            ST_IDLE:      c = CODE_IDLE;
            ST_RECOG:     c = CODE_RECOG;
            ST_DENIED:    c = CODE_DENIED;
            ST_OPENING:   c = CODE_OPENING;
            ST_OPEN:      c = CODE_OPEN;
            ST_PASSING:   c = CODE_PASSING;
            ST_CLEARANCE: c = CODE_CLEARANCE;
            ST_CLOSING:   c = CODE_CLOSING;
            ST_REARMING:  c = CODE_REARMING;
            ST_FAULT:     c = CODE_FAULT;
            default:      c = CODE_STARTUP;
        endcase
        return c;
    endfunction

    tstamp_t          e_at;
    logic [CFG_W-1:0] limit;
    logic             el;
    logic             occ_stable;
    logic             clr_stable;
    logic             do_go;
    gate_st_t         st_go;
    logic             went_pulse;
    logic             ovr_live;
    logic             pulse_live;
    logic             acc;
    logic             green;

    // The first update after reset restarts the time spent in the current state.
    assign e_at = cur.started ? cur.entered_at : item.now;

    always_comb
    begin
        unique case (cur.st)
            ST_RECOG:               limit = cfg.recog_timeout;
            ST_OPENING:             limit = cfg.opening_travel;
            ST_OPEN, ST_PASSING:    limit = cfg.passage_timeout;
            ST_CLEARANCE:           limit = cfg.clearance;
            ST_CLOSING:             limit = cfg.closing_travel;
            default:                limit = '0;
        endcase
    end

    assign el = elapsed(item.now, e_at, limit);

    // A level that starts being seen now is stable at once only with no debounce.
    assign occ_stable = item.loop_present &&
        (cur.occ_valid ? elapsed(item.now, cur.occ_since, cfg.debounce)
                       : (cfg.debounce == '0));
    assign clr_stable = !item.loop_present &&
        (cur.clr_valid ? elapsed(item.now, cur.clr_since, cfg.debounce)
                       : (cfg.debounce == '0));

    always_comb
    begin
        nxt   = cur;
        acc   = 1'b0;
        do_go = 1'b0;
        st_go = cur.st;

        unique case (item.kind)
            KIND_UPDATE:
            begin
                acc            = 1'b1;
                nxt.started    = 1'b1;
                nxt.entered_at = e_at;
                if (cur.ovr_active && at_or_after(item.now, cur.ovr_end))
                    nxt.ovr_active = 1'b0;

                if (cur.st == ST_IDLE || cur.st == ST_REARMING)
                begin
                    nxt.occ_valid = item.loop_present;
                    if (item.loop_present && !cur.occ_valid)
                        nxt.occ_since = item.now;
                end
                if (cur.st == ST_DENIED || cur.st == ST_REARMING)
                begin
                    nxt.clr_valid = !item.loop_present;
                    if (!item.loop_present && !cur.clr_valid)
                        nxt.clr_since = item.now;
                end

                unique case (cur.st)
                    ST_STARTUP:
                    begin
                        nxt.fault_reason = FAULT_NONE;
                        do_go = 1'b1;
                        st_go = ST_IDLE;
                    end
                    ST_IDLE:
                    begin
                        do_go = occ_stable;
                        st_go = ST_RECOG;
                    end
                    ST_RECOG:
                    begin
                        if (el)
                        begin
                            nxt.fault_reason = FAULT_RECOG_TIMEOUT;
                            do_go = 1'b1;
                            st_go = ST_FAULT;
                        end
                    end
                    ST_DENIED:
                    begin
                        do_go = clr_stable;
                        st_go = ST_IDLE;
                    end
                    ST_OPENING:
                    begin
                        do_go = el;
                        st_go = ST_OPEN;
                    end
                    ST_OPEN:
                    begin
                        priority if (item.passage_blocked)
                        begin
                            do_go = 1'b1;
                            st_go = ST_PASSING;
                        end
                        else if (el)
                        begin
                            nxt.fault_reason = FAULT_NO_PASSAGE;
                            do_go = 1'b1;
                            st_go = ST_FAULT;
                        end
                        else
                        begin
                        end
                    end
                    ST_PASSING:
                    begin
                        priority if (!item.passage_blocked)
                        begin
                            do_go = 1'b1;
                            st_go = ST_CLEARANCE;
                        end
                        else if (el)
                        begin
                            nxt.fault_reason = FAULT_BLOCKED;
                            do_go = 1'b1;
                            st_go = ST_FAULT;
                        end
                        else
                        begin
                        end
                    end
                    ST_CLEARANCE:
                    begin
                        priority if (item.passage_blocked)
                        begin
                            do_go = 1'b1;
                            st_go = ST_PASSING;
                        end
                        else if (el)
                        begin
                            do_go = 1'b1;
                            st_go = ST_CLOSING;
                        end
                        else
                        begin
                        end
                    end
                    ST_CLOSING:
                    begin
                        priority if (item.passage_blocked)
                        begin
                            do_go = 1'b1;
                            st_go = ST_OPENING;
                        end
                        else if (el)
                        begin
                            do_go = 1'b1;
                            st_go = ST_REARMING;
                        end
                        else
                        begin
                        end
                    end
                    ST_REARMING:
                    begin
                        priority if (occ_stable)
                        begin
                            do_go = 1'b1;
                            st_go = ST_RECOG;
                        end
                        else if (clr_stable)
                        begin
                            do_go = 1'b1;
                            st_go = ST_IDLE;
                        end
                        else
                        begin
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            KIND_RECOGNITION:
            begin
                if (cur.st == ST_RECOG)
                begin
                    acc   = 1'b1;
                    do_go = 1'b1;
                    priority if (item.system_error)
                    begin
                        nxt.fault_reason = FAULT_RECOG_FAILED;
                        st_go = ST_FAULT;
                    end
                    else if (item.authorized)
                        st_go = ST_OPENING;
                    else
                        st_go = ST_DENIED;
                end
            end
            KIND_ACK_FAULT:
            begin
                if (cur.st == ST_FAULT && !item.passage_blocked)
                begin
                    acc              = 1'b1;
                    nxt.fault_reason = FAULT_NONE;
                    do_go            = 1'b1;
                    st_go            = ST_IDLE;
                end
            end
            KIND_MANUAL_OPEN:
            begin
                acc              = 1'b1;
                nxt.fault_reason = FAULT_NONE;
                nxt.ovr_active   = 1'b0;
                do_go            = 1'b1;
                st_go            = ST_OPENING;
            end
            KIND_MANUAL_CLOSE:
            begin
                if (!item.passage_blocked)
                begin
                    acc              = 1'b1;
                    nxt.fault_reason = FAULT_NONE;
                    nxt.ovr_active   = 1'b0;
                    do_go            = 1'b1;
                    st_go            = ST_CLOSING;
                end
            end
            KIND_LIGHT_TEST:
            begin
                acc            = 1'b1;
                nxt.ovr_active = 1'b1;
                nxt.ovr_level  = item.override_green;
                nxt.ovr_end    = item.now + TIME_W'(item.override_dur);
            end
            default:
            begin
            end
        endcase

        went_pulse = do_go && (st_go == ST_OPENING || st_go == ST_CLOSING);
        if (do_go)
        begin
            nxt.st         = st_go;
            nxt.entered_at = item.now;
            nxt.occ_valid  = 1'b0;
            nxt.clr_valid  = 1'b0;
            if (went_pulse)
                nxt.pulse_end = item.now + TIME_W'(cfg.relay_pulse);
        end

        // A deadline set in this word from now plus a short length is still ahead
        // unless the length is zero, which saves an add ahead of the compare.
        if (item.kind == KIND_LIGHT_TEST)
            ovr_live = (item.override_dur != '0);
        else
            ovr_live = nxt.ovr_active && !at_or_after(item.now, cur.ovr_end);

        if (went_pulse)
            pulse_live = (cfg.relay_pulse != '0);
        else
            pulse_live = !at_or_after(item.now, cur.pulse_end);

        green = (nxt.st == ST_OPENING) || (nxt.st == ST_OPEN) ||
                (nxt.st == ST_PASSING) || (nxt.st == ST_CLEARANCE);
        if (ovr_live)
            green = nxt.ovr_level;

        res.gate_code    = state_code(nxt.st);
        res.green        = green;
        res.req_open     = (nxt.st == ST_OPENING) && pulse_live;
        res.req_close    = (nxt.st == ST_CLOSING) && pulse_live && !item.passage_blocked;
        res.cycle_active = !((nxt.st == ST_STARTUP) || (nxt.st == ST_IDLE) ||
                             (nxt.st == ST_FAULT));
        res.fault_code   = nxt.fault_reason;
        res.accepted     = acc;
    end

endmodule

// ===== design/barrier_gate_sequencer_top.sv =====
// Top level of the barrier gate sequencer: ports, configuration and pipeline registers.
// The sequencer takes one word per clock unless a result waits on m_tready, and returns
// one result word for each: the word is captured in an input register, the state update
// and outputs are computed in one pass of the step logic and written to the state and to
// the result register at the same edge, so the next word already sees the updated state.
// A result waiting on m_tready holds back only the word behind it; one word can sit in the
// input register meanwhile. Configuration registers reset to their default times and are
// written through cfg_wen, cfg_index and cfg_data; the user must write them only while no
// word is in flight (the block does not enforce it); indexes past the last register are ignored.
module barrier_gate_sequencer_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // now_ms[31:0], loop_present, passage_blocked, authorized, system_error,
    // override_green, override_duration_ms[23:0], zero padding
    input  logic [bgs_pkg::IN_DATA_W-1:0]      s_tdata,
    // kind[2:0]
    input  logic [bgs_pkg::KIND_W-1:0]         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // gate_state[3:0], traffic_green, request_open, request_close, cycle_active,
    // fault_code[2:0], accepted, zero padding
    output logic [bgs_pkg::OUT_DATA_W-1:0]     m_tdata,
    input  logic                               cfg_wen,
    input  logic [bgs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bgs_pkg::CFG_W-1:0]          cfg_data
);
    import bgs_pkg::*;

    localparam cfg_t CFG_RESET = '{
        debounce:        CFG_W'(200),
        relay_pulse:     CFG_W'(500),
        recog_timeout:   CFG_W'(5000),
        opening_travel:  CFG_W'(6000),
        passage_timeout: CFG_W'(60000),
        clearance:       CFG_W'(2000),
        closing_travel:  CFG_W'(6000)
    };

    localparam ctx_t CTX_RESET = '{
        st:           ST_STARTUP,
        started:      1'b0,
        entered_at:   '0,
        occ_since:    '0,
        occ_valid:    1'b0,
        clr_since:    '0,
        clr_valid:    1'b0,
        pulse_end:    '0,
        ovr_active:   1'b0,
        ovr_level:    1'b0,
        ovr_end:      '0,
        fault_reason: FAULT_NONE
    };

    cfg_t                  cfg_reg, cfg_next;
    logic                  in_valid_reg, in_valid_next;
    item_t                 in_item_reg, in_item_next;
    ctx_t                  ctx_reg, ctx_next;
    logic                  out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;

    ctx_t                  step_ctx;
    result_t               step_res;
    logic                  advance;
    logic                  in_take;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wen)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_DEBOUNCE:        cfg_next.debounce        = cfg_data;
                REG_RELAY_PULSE:     cfg_next.relay_pulse     = cfg_data;
                REG_RECOG_TIMEOUT:   cfg_next.recog_timeout   = cfg_data;
                REG_OPENING_TRAVEL:  cfg_next.opening_travel  = cfg_data;
                REG_PASSAGE_TIMEOUT: cfg_next.passage_timeout = cfg_data;
                REG_CLEARANCE:       cfg_next.clearance       = cfg_data;
                REG_CLOSING_TRAVEL:  cfg_next.closing_travel  = cfg_data;
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        in_item_next.kind            = kind_t'(s_tuser);
        in_item_next.now             = TIME_W'(s_tdata[NOW_W-1:0]);
        in_item_next.loop_present    = s_tdata[NOW_W];
        in_item_next.passage_blocked = s_tdata[NOW_W+1];
        in_item_next.authorized      = s_tdata[NOW_W+2];
        in_item_next.system_error    = s_tdata[NOW_W+3];
        in_item_next.override_green  = s_tdata[NOW_W+4];
        in_item_next.override_dur    = s_tdata[NOW_W+5 +: DUR_W];
    end

    bgs_step u_step (
        .cfg  (cfg_reg),
        .cur  (ctx_reg),
        .item (in_item_reg),
        .nxt  (step_ctx),
        .res  (step_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_tready)
            in_valid_next = s_tvalid;

        ctx_next       = advance ? step_ctx : ctx_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            out_data_next  = OUT_DATA_W'({step_res.accepted, step_res.fault_code,
                                          step_res.cycle_active, step_res.req_close,
                                          step_res.req_open, step_res.green,
                                          step_res.gate_code});
        end
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg       <= CFG_RESET;
            in_valid_reg  <= 1'b0;
            ctx_reg       <= CTX_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            ctx_reg       <= ctx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            in_item_reg <= in_item_next;
        out_data_reg <= out_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== design/bgs_checker.sv =====
// Port-level checks of the barrier gate sequencer, bound to its top level.
`include "barrier_gate_sequencer_top_defines.svh"

module bgs_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bgs_pkg::OUT_DATA_W-1:0] m_tdata
);
    import bgs_pkg::*;

    logic [CODE_W-1:0]  out_code;
    logic [FAULT_W-1:0] out_fault;
    logic               in_offered;

    assign out_code   = m_tdata[OUT_CODE_LSB +: CODE_W];
    assign out_fault  = m_tdata[OUT_FAULT_LSB +: FAULT_W];
    assign in_offered = s_tvalid;

    // A stalled result stays put until it is taken.
    `BGS_ASSERT_NEXT(a_result_holds, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // With no result waiting the input side never stalls.
    `BGS_ASSERT_NOW(a_ready_when_empty, !m_tvalid && in_offered, s_tready)

    // A fault reason is reported only while the gate sits in the fault state.
    `BGS_ASSERT_NOW(a_fault_only_in_fault, m_tvalid && (out_fault != FAULT_NONE), out_code == CODE_FAULT)

    // The open relay is driven only while opening, which is part of a cycle.
    `BGS_ASSERT_NOW(a_open_only_opening, m_tvalid && m_tdata[OUT_OPEN_BIT], (out_code == CODE_OPENING) && m_tdata[OUT_CYCLE_BIT])

endmodule

bind barrier_gate_sequencer_top bgs_checker u_bgs_checker (.*);
